// ===== hw/rtl/xfde_pkg.sv =====
package xfde_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int CODE_WIDTH = 43;
	localparam int LEN_WIDTH  = 6;
	localparam int CNT_WIDTH  = 16;
	localparam int LEAD_WIDTH = 4;
	localparam int TZ_WIDTH   = 5;

	localparam logic [LEAD_WIDTH-1:0] LEAD_CAP           = 4'd15;
	localparam logic [CNT_WIDTH-1:0]  BLOCK_LENGTH_RESET = 16'd1024;
	localparam logic [TZ_WIDTH-1:0]   WINDOW_LEAD_RESET  = 5'd31;
	localparam logic [LEN_WIDTH-1:0]  RAW_LENGTH         = 6'd32;
	localparam logic [LEN_WIDTH-1:0]  ZERO_LENGTH        = 6'd1;
	localparam logic [LEN_WIDTH-1:0]  FIT_OVERHEAD       = 6'd2;
	localparam logic [LEN_WIDTH-1:0]  NEW_OVERHEAD       = 6'd11;
	localparam logic [1:0]            TAG_FIT            = 2'b10;
	localparam logic [1:0]            TAG_NEW            = 2'b11;

	// stored leading/trailing window
	typedef struct packed {
		logic [TZ_WIDTH-1:0] lead;
		logic [TZ_WIDTH-1:0] trail;
	} win_t;

	// encoder state as seen by the encode logic
	typedef struct packed {
		logic                  first;
		logic [WORD_WIDTH-1:0] prev;
		win_t                  win;
	} enc_state_t;

	typedef struct packed {
		logic [CODE_WIDTH-1:0] code;
		logic [LEN_WIDTH-1:0]  len;
		logic                  win_load;
		win_t                  win;
	} enc_result_t;

	// leading zeros, 32 for an all-zero word
	function automatic logic [LEN_WIDTH-1:0] lead_zeros(input logic [WORD_WIDTH-1:0] x);
		logic [LEN_WIDTH-1:0] n;
		n = LEN_WIDTH'(WORD_WIDTH);
		for (int i = 0; i < WORD_WIDTH; i++) begin
			if (x[i])
				n = LEN_WIDTH'(WORD_WIDTH - 1 - i);
		end
		return n;
	endfunction

	// trailing zeros, 32 for an all-zero word
	function automatic logic [LEN_WIDTH-1:0] trail_zeros(input logic [WORD_WIDTH-1:0] x);
		logic [LEN_WIDTH-1:0] n;
		n = LEN_WIDTH'(WORD_WIDTH);
		for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
			if (x[i])
				n = LEN_WIDTH'(i);
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/xfde_encode.sv =====
module xfde_encode import xfde_pkg::*; (
	input  logic [WORD_WIDTH-1:0] word,
	input  enc_state_t            state,
	output enc_result_t           result
);

	logic [WORD_WIDTH-1:0] x;
	logic [LEN_WIDTH-1:0]  lz;
	logic [LEN_WIDTH-1:0]  tz_full;
	logic [LEAD_WIDTH-1:0] lead;
	logic [TZ_WIDTH-1:0]   trail;
	logic                  fits;
	logic [LEN_WIDTH-1:0]  sig_fit;
	logic [LEN_WIDTH-1:0]  sig_new;
	logic [10:0]           head;

	assign x       = state.prev ^ word;
	assign lz      = lead_zeros(x);
	assign tz_full = trail_zeros(x);
	assign lead    = (lz > LEN_WIDTH'(LEAD_CAP)) ? LEAD_CAP : lz[LEAD_WIDTH-1:0];
	assign trail   = tz_full[TZ_WIDTH-1:0];

	assign fits = ({1'b0, lead} >= state.win.lead) && (trail >= state.win.trail) &&
		(({1'b0, state.win.lead} + {1'b0, state.win.trail}) < LEN_WIDTH'(WORD_WIDTH));

	assign sig_fit = LEN_WIDTH'(WORD_WIDTH) - {1'b0, state.win.lead} - {1'b0, state.win.trail};
	assign sig_new = LEN_WIDTH'(WORD_WIDTH) - {2'b0, lead} - {1'b0, trail};
	assign head    = {TAG_NEW, lead, sig_new[TZ_WIDTH-1:0]};

	// bits above the meaningful span are already zero, so no mask is needed
	always_comb begin
		result.win_load  = 1'b0;
		result.win.lead  = {1'b0, lead};
		result.win.trail = trail;
		if (state.first) begin
			result.code = CODE_WIDTH'(word);
			result.len  = RAW_LENGTH;
		end else if (x == '0) begin
			result.code = '0;
			result.len  = ZERO_LENGTH;
		end else if (fits) begin
			result.code = (CODE_WIDTH'(TAG_FIT) << sig_fit) |
				CODE_WIDTH'(x >> state.win.trail);
			result.len  = FIT_OVERHEAD + sig_fit;
		end else begin
			result.code = (CODE_WIDTH'(head) << sig_new) | CODE_WIDTH'(x >> trail);
			result.len  = NEW_OVERHEAD + sig_new;
			result.win_load = 1'b1;
		end
	end

endmodule

// ===== hw/rtl/xfde_block_ctr.sv =====
module xfde_block_ctr import xfde_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CNT_WIDTH-1:0] cfg_data,
	input  logic                 advance,
	output logic                 block_end
);

	logic [CNT_WIDTH-1:0] length_q;
	logic [CNT_WIDTH-1:0] count_q;
	logic [CNT_WIDTH:0]   count_inc;

	// a length of zero never matches since the increment is at least one
	assign count_inc = {1'b0, count_q} + 1'b1;
	assign block_end = (count_inc == {1'b0, length_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= BLOCK_LENGTH_RESET;
			count_q  <= '0;
		end else begin
			if (cfg_valid)
				length_q <= cfg_data;
			if (advance)
				count_q <= block_end ? '0 : count_inc[CNT_WIDTH-1:0];
		end
	end

endmodule

// ===== hw/rtl/xor_float_delta_encoder.sv =====
// XOR float delta encoder.
// Input channel (in_valid/in_ready, sample_bits) takes one 32-bit float bit
// pattern per transaction. Output channel (out_valid/out_ready) gives one
// codeword per input: code_bits right-aligned with its first bit at
// code_length-1, code_length from 1 to 43, and block_end on every
// block_length-th item.
// Configuration channel (cfg_valid/cfg_ready, block_length) is always ready;
// write it only while no item is in flight. Writing it does not clear the
// item count within the current block.
// An accepted item sits in the input register, passes the XOR / zero-count /
// window logic and lands in the output register. Throughput is one item per
// cycle while the receiver takes codewords, set by the update of the previous
// word and window that each item depends on.
// Reset: the first item after reset is sent raw as 32 bits, the window is
// forced open and block_length returns to 1024.
// When the receiver stalls, the output register holds its codeword, the
// input register takes one more item, and in_ready then drops.
module xor_float_delta_encoder import xfde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [WORD_WIDTH-1:0] sample_bits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CODE_WIDTH-1:0] code_bits,
	output logic [LEN_WIDTH-1:0]  code_length,
	output logic                  block_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_WIDTH-1:0]  block_length
);

	logic                  valid_s1;
	logic [WORD_WIDTH-1:0] word_s1;
	logic                  out_valid_q;
	logic [CODE_WIDTH-1:0] code_q;
	logic [LEN_WIDTH-1:0]  len_q;
	logic                  end_q;
	logic                  first_q;
	logic [WORD_WIDTH-1:0] prev_q;
	win_t                  win_q;
	enc_state_t            state;
	enc_result_t           result;
	logic                  advance;
	logic                  blk_end;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign state.first = first_q;
	assign state.prev  = prev_q;
	assign state.win   = win_q;

	xfde_encode u_encode (
		.word   (word_s1),
		.state  (state),
		.result (result)
	);

	xfde_block_ctr u_block_ctr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (block_length),
		.advance   (advance),
		.block_end (blk_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			first_q     <= 1'b1;
			prev_q      <= '0;
			win_q.lead  <= WINDOW_LEAD_RESET;
			win_q.trail <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			// advance the encoder state with the item leaving the input register
			if (advance) begin
				first_q <= 1'b0;
				prev_q  <= word_s1;
				if (result.win_load)
					win_q <= result.win;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			word_s1 <= sample_bits;
		if (advance) begin
			code_q <= result.code;
			len_q  <= result.len;
			end_q  <= blk_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_bits   = code_q;
	assign code_length = len_q;
	assign block_end   = end_q;

endmodule

// ===== dv/xor_float_delta_encoder_tb.sv =====
module xor_float_delta_encoder_tb import xfde_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 150;
	localparam int MAX_WAIT    = 17;
	localparam int CHUNK       = 50;

	typedef struct packed {
		logic [CODE_WIDTH-1:0] code;
		logic [LEN_WIDTH-1:0]  len;
		logic                  last_in_block;
	} codeword_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [WORD_WIDTH-1:0] sample_bits = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CODE_WIDTH-1:0] code_bits;
	logic [LEN_WIDTH-1:0]  code_length;
	logic                  block_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CNT_WIDTH-1:0]  block_length = '0;

	xor_float_delta_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_bits (sample_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_bits   (code_bits),
		.code_length (code_length),
		.block_end   (block_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.block_length(block_length)
	);

	always #2 clk = ~clk;

	// encoder state as predicted
	bit                    enc_first = 1'b1;
	logic [WORD_WIDTH-1:0] enc_prev = '0;
	int                    win_lead = int'(WINDOW_LEAD_RESET);
	int                    win_trail = 0;
	int                    blk_count = 0;
	int                    blk_len = int'(BLOCK_LENGTH_RESET);

	logic [WORD_WIDTH-1:0] sample_q[$];
	codeword_t             codeword_q[$];
	int                    mismatches = 0;
	int                    cycle_count = 0;

	bit in_took = 1'b0;
	bit out_took = 1'b0;
	bit cfg_took = 1'b0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;
	int send_gap = 0;
	int recv_wait = 0;
	int hold_left = 0;
	int long_req = 0;
	int long_ack = 0;

	// stimulus shaping
	logic [WORD_WIDTH-1:0] gen_last = '0;
	int                    gen_lo = 4;
	int                    gen_hi = 20;
	bit                    allow_full = 1'b0;

	logic [WORD_WIDTH-1:0] directed_words [20] = '{
		32'h3F800000, 32'h3F800000, 32'h3F800100, 32'h3F800000, 32'h3F810000,
		32'h3F800000, 32'h3F800001, 32'h3F800000, 32'h7F800000, 32'h3F800000,
		32'hBF800000, 32'h3F800000, 32'hBF800100, 32'hBF800100, 32'h3F800000,
		32'h00000000, 32'h7FFFFF00, 32'hFFFFFF00, 32'hFFFFFFFF, 32'hFFFFFFFE
	};

	function automatic codeword_t encode_sample(input logic [WORD_WIDTH-1:0] word);
		codeword_t             cw;
		logic [WORD_WIDTH-1:0] x;
		logic [63:0]           bits;
		int                    lz;
		int                    tz;
		int                    sig;
		cw = '0;
		if (enc_first) begin
			cw.code = CODE_WIDTH'(word);
			cw.len = RAW_LENGTH;
			enc_first = 1'b0;
		end else begin
			x = enc_prev ^ word;
			if (x == '0) begin
				cw.len = ZERO_LENGTH;
			end else begin
				lz = 0;
				while (!x[WORD_WIDTH-1-lz])
					lz++;
				tz = 0;
				while (!x[tz])
					tz++;
				// leading count saturates; the extra zeros ride in the payload
				if (lz > int'(LEAD_CAP))
					lz = int'(LEAD_CAP);
				if (lz >= win_lead && tz >= win_trail && win_lead + win_trail < WORD_WIDTH) begin
					sig = WORD_WIDTH - win_lead - win_trail;
					bits = (64'(x) >> win_trail) & ((64'd1 << sig) - 64'd1);
					cw.code = CODE_WIDTH'((64'(TAG_FIT) << sig) | bits);
					cw.len = FIT_OVERHEAD + LEN_WIDTH'(sig);
				end else begin
					sig = WORD_WIDTH - lz - tz;
					bits = (64'(x) >> tz) & ((64'd1 << sig) - 64'd1);
					cw.code = CODE_WIDTH'((64'({TAG_NEW, LEAD_WIDTH'(lz), TZ_WIDTH'(sig)})
						<< sig) | bits);
					cw.len = NEW_OVERHEAD + LEN_WIDTH'(sig);
					win_lead = lz;
					win_trail = tz;
				end
			end
		end
		enc_prev = word;
		if (blk_count + 1 == blk_len) begin
			cw.last_in_block = 1'b1;
			blk_count = 0;
		end else begin
			blk_count = (blk_count + 1) % (1 << CNT_WIDTH);
		end
		return cw;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 100)
			$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin : monitor
		codeword_t want;
		in_took <= arst_n && in_valid && in_ready;
		out_took <= arst_n && out_valid && out_ready;
		cfg_took <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				blk_len = int'(block_length);
			if (in_valid && in_ready)
				codeword_q.push_back(encode_sample(sample_bits));
			if (out_valid && out_ready) begin
				if (codeword_q.size() == 0) begin
					report_mismatch("unexpected codeword", 64'(code_bits), '0);
				end else begin
					want = codeword_q.pop_front();
					if (code_bits !== want.code)
						report_mismatch("code_bits", 64'(code_bits), 64'(want.code));
					if (code_length !== want.len)
						report_mismatch("code_length", 64'(code_length), 64'(want.len));
					if (block_end !== want.last_in_block)
						report_mismatch("block_end", 64'(block_end), 64'(want.last_in_block));
				end
			end
		end
	end

	// driver: hold valid until the transaction goes through, then idle or advance
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sample_q.size() != 0) begin
				in_valid <= 1'b1;
				sample_bits <= sample_q.pop_front();
				send_gap <= send_burst ? 0 : $urandom_range(0, MAX_WAIT);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: per-transaction stall, plus an occasional long hold-off
	always @(negedge clk) begin : receiver
		int stall;
		if (arst_n) begin
			if (long_req != long_ack) begin
				long_ack <= long_req;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= (hold_left == 1);
			end else if (out_took) begin
				stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
				recv_wait <= stall;
				out_ready <= (stall == 0);
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= (recv_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_sample(input logic [WORD_WIDTH-1:0] word);
		gen_last = word;
		sample_q.push_back(word);
	endtask

	// mostly small bit flips inside a drifting window, so both the fitting and
	// the new-window paths stay busy; keep the window off full width until allowed
	function automatic logic [WORD_WIDTH-1:0] next_sample();
		logic [WORD_WIDTH-1:0] cand;
		logic [WORD_WIDTH-1:0] mask;
		int                    pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			gen_lo = $urandom_range(0, WORD_WIDTH - 1);
			gen_hi = $urandom_range(gen_lo, WORD_WIDTH - 1);
		end
		if (pick < 20) begin
			cand = gen_last;
		end else if (pick < 75) begin
			mask = (32'hFFFFFFFF >> (WORD_WIDTH - 1 - gen_hi)) & (32'hFFFFFFFF << gen_lo);
			mask = mask & $urandom();
			if (pick < 40) begin
				mask[gen_hi] = 1'b1;
				mask[gen_lo] = 1'b1;
			end
			if (mask == '0)
				mask[gen_lo] = 1'b1;
			cand = gen_last ^ mask;
		end else if (pick < 90) begin
			cand = $urandom();
		end else begin
			case ($urandom_range(0, 3))
				0: cand = 32'h00000000;
				1: cand = 32'hFFFFFFFF;
				2: cand = 32'h80000000;
				default: cand = 32'h00000001;
			endcase
		end
		if (!allow_full && cand[WORD_WIDTH-1] != gen_last[WORD_WIDTH-1] && cand[0] != gen_last[0])
			cand[0] = gen_last[0];
		return cand;
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || in_valid || codeword_q.size() != 0);
	endtask

	task automatic write_block_length(input logic [CNT_WIDTH-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		block_length <= value;
		do
			@(negedge clk);
		while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [CNT_WIDTH-1:0] len, input int items,
			input bit long_hold, input bit full);
		int left;
		int chunk;
		bit burst;
		bit first;
		wait_drained();
		write_block_length(len);
		allow_full = full;
		left = items;
		first = 1'b1;
		if (full) begin
			// all-ones difference: widest new window, then the same inside it
			@(posedge clk);
			queue_sample(gen_last ^ 32'hFFFFFFFF);
			queue_sample(gen_last ^ 32'hFFFFFFFF);
			left -= 2;
		end
		while (left > 0) begin
			chunk = (left > CHUNK) ? CHUNK : left;
			burst = ($urandom_range(0, 3) == 0) || (long_hold && first);
			@(negedge clk);
			send_burst <= burst;
			recv_burst <= ($urandom_range(0, 3) == 0);
			if (long_hold && first)
				long_req <= long_req + 1;
			first = 1'b0;
			@(posedge clk);
			repeat (chunk)
				queue_sample(next_sample());
			left -= chunk;
			do
				@(negedge clk);
			while (sample_q.size() != 0);
			if ($urandom_range(0, 2) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_block_length(16'd1);
		@(posedge clk);
		foreach (directed_words[i])
			queue_sample(directed_words[i]);
		run_phase(16'd3, 250, 1'b0, 1'b0);
		run_phase(16'd7, 350, 1'b1, 1'b0);
		run_phase(16'd1024, 150, 1'b0, 1'b0);
		run_phase(16'd200, 100, 1'b0, 1'b0);
		// count already past the new length: no block end until wraparound
		run_phase(16'd40, 250, 1'b0, 1'b0);
		run_phase(16'd0, 200, 1'b0, 1'b0);
		run_phase(16'd65535, 250, 1'b0, 1'b1);
		wait_drained();
		repeat (8)
			@(negedge clk);
		if (mismatches == 0 && codeword_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/xfde_pkg.sv
hw/rtl/xfde_encode.sv
hw/rtl/xfde_block_ctr.sv
hw/rtl/xor_float_delta_encoder.sv
dv/xor_float_delta_encoder_tb.sv
